// ===== rtl/pidaw_pkg.sv =====
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared widths, register indexes and stage types for the angle-wrap PID core.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int GAIN_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int ERR_W    = 17;   // error after wrap
  localparam int DIFF_W   = 18;   // error minus previous error
  localparam int ACC_W    = 32;   // clamped error sum
  localparam int SLIM_W   = 31;
  localparam int DLIM_W   = 15;
  localparam int HALF_W   = 15;
  localparam int DRIVE_W  = 16;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int FRAC_W   = 8;    // Q8.8 gains

  localparam int PP_W  = GAIN_W + ERR_W;    // 33
  localparam int PI_W  = GAIN_W + ACC_W;    // 48
  localparam int PD_W  = GAIN_W + DIFF_W;   // 34
  localparam int SUM_W = PI_W + 2;          // 50

  localparam logic [HALF_W-1:0] HALF_TURN_RST = HALF_W'(11520);

  typedef enum logic [CFG_AW-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_SUM_LIMIT   = 3'd3,
    REG_DRIVE_LIMIT = 3'd4,
    REG_ANGLE_MODE  = 3'd5,
    REG_HALF_TURN   = 3'd6
  } cfg_reg_t;

  // one item leaving the error stage
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [ACC_W-1:0]  accum;
    logic signed [DIFF_W-1:0] diff;
  } err_item_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
  } gains_t;

endpackage

// ===== rtl/pidaw_drive.sv =====
// ----------------------------------------------------------------------------
// pidaw_drive
// Gain products, Q8.8 rescale and output clamp, two register stages.
// ----------------------------------------------------------------------------
module pidaw_drive
  import pidaw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  gains_t                   gains,
  input  logic [DLIM_W-1:0]        drive_limit,
  input  logic                     s_valid,
  output logic                     s_ready,
  input  err_item_t                s_item,
  output logic                     m_valid,
  input  logic                     m_ready,
  output logic signed [DRIVE_W-1:0] m_drive
);

  logic                     prod_v_r;
  logic signed [PP_W-1:0]   pp_r;
  logic signed [PI_W-1:0]   pi_r;
  logic signed [PD_W-1:0]   pd_r;
  logic                     out_v_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic signed [DRIVE_W-1:0] drive_nxt;

  logic prod_adv;
  logic out_adv;

  logic signed [SUM_W-1:0]        sum;
  logic signed [SUM_W-FRAC_W-1:0] scaled;
  logic signed [SUM_W-FRAC_W-1:0] lim_pos;
  logic signed [SUM_W-FRAC_W-1:0] lim_neg;

  assign out_adv  = !out_v_r || m_ready;
  assign prod_adv = !prod_v_r || out_adv;
  assign s_ready  = prod_adv;
  assign m_valid  = out_v_r;
  assign m_drive  = drive_r;

  always_comb begin
    sum     = SUM_W'(pp_r) + SUM_W'(pi_r) + SUM_W'(pd_r);
    // arithmetic shift gives the floor
    scaled  = (SUM_W-FRAC_W)'(sum >>> FRAC_W);
    lim_pos = (SUM_W-FRAC_W)'($signed({1'b0, drive_limit}));
    lim_neg = -lim_pos;
    if (scaled < lim_neg) begin
      drive_nxt = DRIVE_W'(lim_neg);
    end else if (scaled > lim_pos) begin
      drive_nxt = DRIVE_W'(lim_pos);
    end else begin
      drive_nxt = DRIVE_W'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (prod_adv) begin
        prod_v_r <= s_valid;
      end
      if (out_adv) begin
        out_v_r <= prod_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_adv && s_valid) begin
      pp_r <= gains.gain_p * s_item.err;
      pi_r <= gains.gain_i * s_item.accum;
      pd_r <= gains.gain_d * s_item.diff;
    end
    if (out_adv && prod_v_r) begin
      drive_r <= drive_nxt;
    end
  end

  a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    prod_v_r && !out_adv |=> prod_v_r && $stable(pp_r) && $stable(pi_r) && $stable(pd_r))
    else $error("product stage changed while stalled");

  a_out_from_prod: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(prod_v_r))
    else $error("result appeared without a product");

  a_prod_moves: assert property (@(posedge clk) disable iff (!rst_n)
    prod_v_r && out_adv |=> out_v_r)
    else $error("product lost on its way to the result register");

endmodule

// ===== rtl/pid_controller_angle_wrap_core.sv =====
// ----------------------------------------------------------------------------
// pid_controller_angle_wrap_core
// Positional PID step with integral clamp and optional half-turn error wrap.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction carries setpoint (tdata[15:0]) and measured
//           (tdata[31:16]), both signed.
//   out_* : one transaction per input carries the signed drive in tdata.
//   cfg_* : register writes by index (gains, limits, angle mode, half turn);
//           cfg_ready is always high. Write only while the core is idle.
// Timing:
//   four register stages: input, error/integrator, gain products, result.
//   The result passes the input, error, product and result stages in that
//   order, and one item can enter every cycle while out_tready is high;
//   the integrator and previous-error state update on the same clock edge
//   that loads the error stage, which is what allows that rate.
// Reset:
//   rst_n (synchronous) empties the pipeline, clears the integrator and
//   previous error, zeroes gains and limits, angle mode off, half turn 11520.
// Stall:
//   when out_tready is low each stage holds once full; in_tready drops only
//   when every stage holds an item, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pid_controller_angle_wrap_core
  import pidaw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,     // setpoint [15:0], measured [31:16]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,    // drive [15:0]
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data
);

  // configuration
  gains_t              gains_r;
  logic [SLIM_W-1:0]   sum_limit_r;
  logic [DLIM_W-1:0]   drive_limit_r;
  logic                angle_mode_r;
  logic [HALF_W-1:0]   half_turn_r;

  // input stage
  logic                        in_v_r;
  logic signed [SAMPLE_W-1:0]  setpoint_r;
  logic signed [SAMPLE_W-1:0]  measured_r;

  // error stage and loop state
  logic                        err_v_r;
  err_item_t                   err_r;
  err_item_t                   err_nxt;
  logic signed [ACC_W-1:0]     accum_r;
  logic signed [ERR_W-1:0]     prev_err_r;

  logic in_adv;
  logic err_adv;
  logic drv_ready;
  logic step;

  logic signed [ERR_W:0]   raw_err;
  logic signed [ERR_W:0]   half_s;
  logic signed [ERR_W:0]   wrapped;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W:0]   slim_pos;
  logic signed [ACC_W:0]   slim_neg;
  logic signed [ACC_W-1:0] acc_clamped;
  logic signed [DRIVE_W-1:0] drive;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r       <= '0;
      sum_limit_r   <= '0;
      drive_limit_r <= '0;
      angle_mode_r  <= 1'b0;
      half_turn_r   <= HALF_TURN_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_addr))
        REG_GAIN_P:      gains_r.gain_p <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:      gains_r.gain_i <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:      gains_r.gain_d <= cfg_data[GAIN_W-1:0];
        REG_SUM_LIMIT:   sum_limit_r    <= cfg_data[SLIM_W-1:0];
        REG_DRIVE_LIMIT: drive_limit_r  <= cfg_data[DLIM_W-1:0];
        REG_ANGLE_MODE:  angle_mode_r   <= cfg_data[0];
        REG_HALF_TURN:   half_turn_r    <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  assign err_adv   = !err_v_r || drv_ready;
  assign in_adv    = !in_v_r || err_adv;
  assign in_tready = in_adv;
  assign step      = in_v_r && err_adv;

  // error, wrap and clamped integrator
  always_comb begin
    raw_err = (ERR_W+1)'(setpoint_r) - (ERR_W+1)'(measured_r);
    half_s  = (ERR_W+1)'($signed({1'b0, half_turn_r}));
    wrapped = raw_err;
    if (angle_mode_r) begin
      if (raw_err < -half_s) begin
        wrapped = raw_err + (half_s <<< 1);
      end else if (raw_err > half_s) begin
        wrapped = raw_err - (half_s <<< 1);
      end
    end
    err_nxt.err = ERR_W'(wrapped);

    acc_sum  = (ACC_W+1)'(accum_r) + (ACC_W+1)'(err_nxt.err);
    slim_pos = (ACC_W+1)'($signed({1'b0, sum_limit_r}));
    slim_neg = -slim_pos;
    if (acc_sum < slim_neg) begin
      acc_clamped = ACC_W'(slim_neg);
    end else if (acc_sum > slim_pos) begin
      acc_clamped = ACC_W'(slim_pos);
    end else begin
      acc_clamped = ACC_W'(acc_sum);
    end
    err_nxt.accum = acc_clamped;
    err_nxt.diff  = DIFF_W'(err_nxt.err) - DIFF_W'(prev_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      err_v_r    <= 1'b0;
      accum_r    <= '0;
      prev_err_r <= '0;
    end else begin
      if (in_adv) begin
        in_v_r <= in_tvalid;
      end
      if (err_adv) begin
        err_v_r <= in_v_r;
      end
      if (step) begin
        accum_r    <= acc_clamped;
        prev_err_r <= err_nxt.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_tvalid) begin
      setpoint_r <= in_tdata[SAMPLE_W-1:0];
      measured_r <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
    if (step) begin
      err_r <= err_nxt;
    end
  end

  pidaw_drive u_drive (
    .clk         (clk),
    .rst_n       (rst_n),
    .gains       (gains_r),
    .drive_limit (drive_limit_r),
    .s_valid     (err_v_r),
    .s_ready     (drv_ready),
    .s_item      (err_r),
    .m_valid     (out_tvalid),
    .m_ready     (out_tready),
    .m_drive     (drive)
  );

  assign out_tdata = drive;

  a_state_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(accum_r) && $stable(prev_err_r))
    else $error("loop state moved without an item");

  // a wrap moves the error one full turn towards zero
  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && angle_mode_r && (half_turn_r != '0) |->
      ((raw_err > half_s)  ? ((wrapped > -half_s) && (wrapped < raw_err)) :
       (raw_err < -half_s) ? ((wrapped < half_s) && (wrapped > raw_err)) :
                             (wrapped == raw_err)))
    else $error("wrap moved the error the wrong way");

  a_err_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(err_v_r) |-> $past(in_v_r))
    else $error("error stage filled without an input");

endmodule
